[design/sbgc_pkg.sv]
// ----------------------------------------------------------------------------
// sbgc_pkg
// Shared types and constants of the seven-bit group codec.
// ----------------------------------------------------------------------------
package sbgc_pkg;

   localparam int MAX_RESULTS = 5;
   localparam int GROUP_MAX   = 4;
   localparam int HELD_DEPTH  = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int ADDR_W      = 3;
   localparam int IDX_W       = 3;

   localparam logic [7:0] DATA_MASK = 8'h7F;

   localparam logic DIR_ENCODE   = 1'b0;
   localparam logic DIR_DECODE   = 1'b1;
   localparam logic REG_DIRECTION = 1'b0;

   typedef struct packed {
      logic wr_en;
      logic direction;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]                  num_out;
      logic [MAX_RESULTS-1:0][7:0]       data;
      logic                              msg_end;
      logic                              bad;
   } job_type;

endpackage

[design/sbgc_front.sv]
// ----------------------------------------------------------------------------
// sbgc_front
// Accepts items, tracks group state and builds one job per result run.
// ----------------------------------------------------------------------------
module sbgc_front
   import sbgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_message_end,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   logic [2:0] group_count_ff, group_count_in;
   logic [7:0] group_header_ff, group_header_in;
   logic [2:0] group_position_ff, group_position_in;
   logic [7:0] held_ff [HELD_DEPTH];
   logic [7:0] held_in [HELD_DEPTH];

   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      logic [1:0] gc;
      logic [2:0] n;
      logic [7:0] grp [GROUP_MAX];
      logic [7:0] hdr;
      logic [3:0] cnt_in;
      logic [1:0] slot;
      logic [3:0] nib;
      logic       need_header;
      logic       job;

      group_count_in    = group_count_ff;
      group_header_in   = group_header_ff;
      group_position_in = group_position_ff;
      for (int i = 0; i < HELD_DEPTH; i++) begin
         held_in[i] = held_ff[i];
      end
      job              = 1'b0;
      push_job         = '0;
      push_job.msg_end = req_message_end;

      gc = (group_count_ff > 3'd3) ? 2'd0 : group_count_ff[1:0];
      n  = {1'b0, gc} + 3'd1;
      for (int i = 0; i < HELD_DEPTH; i++) begin
         grp[i] = (2'(i) < gc) ? held_ff[i] : req_in_byte;
      end
      grp[GROUP_MAX-1] = req_in_byte;
      hdr = {1'b0, n, 4'b0000};
      for (int i = 0; i < GROUP_MAX; i++) begin
         if (2'(i) <= gc) begin
            hdr[3-i] = grp[i][7];
         end
      end

      cnt_in      = req_in_byte[7:4];
      slot        = 2'(group_position_ff - 3'd1);
      nib         = group_header_ff[3:0];
      need_header = (group_position_ff == 3'd0) || (group_position_ff > group_count_ff)
                    || (group_count_ff > 3'd4);

      priority if (cfg.wr_en) begin
         group_count_in    = '0;
         group_header_in   = '0;
         group_position_in = '0;
      end else if (accept) begin
         if (cfg.direction == DIR_ENCODE) begin
            if (gc < 2'd3 && !req_message_end) begin
               for (int i = 0; i < HELD_DEPTH; i++) begin
                  if (2'(i) == gc) begin
                     held_in[i] = req_in_byte;
                  end
               end
               group_count_in = {1'b0, gc} + 3'd1;
            end else begin
               job              = 1'b1;
               push_job.num_out = n + 3'd1;
               push_job.data[0] = hdr;
               for (int i = 0; i < GROUP_MAX; i++) begin
                  push_job.data[i+1] = grp[i] & DATA_MASK;
               end
               group_count_in = '0;
            end
         end else if (need_header) begin
            group_position_in = '0;
            if (cnt_in == 4'd0 || cnt_in > 4'd4) begin
               job              = 1'b1;
               push_job.num_out = 3'd1;
               push_job.bad     = 1'b1;
               group_count_in   = '0;
               group_header_in  = '0;
            end else if (req_message_end) begin
               group_count_in  = '0;
               group_header_in = '0;
            end else begin
               group_count_in    = cnt_in[2:0];
               group_header_in   = req_in_byte;
               group_position_in = 3'd1;
            end
         end else begin
            job              = 1'b1;
            push_job.num_out = 3'd1;
            push_job.data[0] = {nib[2'd3 - slot] | req_in_byte[7], req_in_byte[6:0]};
            if (req_message_end || group_position_ff >= group_count_ff) begin
               group_count_in    = '0;
               group_header_in   = '0;
               group_position_in = '0;
            end else begin
               group_position_in = group_position_ff + 3'd1;
            end
         end
      end
      push = job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff    <= '0;
         group_header_ff   <= '0;
         group_position_ff <= '0;
      end else begin
         group_count_ff    <= group_count_in;
         group_header_ff   <= group_header_in;
         group_position_ff <= group_position_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
         held_ff[i] <= held_in[i];
      end
   end

endmodule

[design/sbgc_queue.sv]
// ----------------------------------------------------------------------------
// sbgc_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sbgc_queue
   import sbgc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/sbgc_back.sv]
// ----------------------------------------------------------------------------
// sbgc_back
// Steps through the head job and drives one result item per cycle while the queue holds a job and rsp_ready is high.
// ----------------------------------------------------------------------------
module sbgc_back
   import sbgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_message_done,
   output logic       rsp_bad_header
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_byte_ff;
   logic             run_last_ff;
   logic             message_done_ff;
   logic             bad_header_ff;

   logic             load;
   logic             take;
   logic             last;

   assign load = !rsp_valid_ff || rsp_ready;
   assign take = load && !empty;
   assign last = (idx_ff == head_job.num_out - IDX_W'(1));
   assign pop  = take && last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         idx_in       = last ? '0 : idx_ff + IDX_W'(1);
         rsp_valid_in = 1'b1;
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff     <= head_job.data[idx_ff];
         run_last_ff     <= last;
         message_done_ff <= last && head_job.msg_end;
         bad_header_ff   <= head_job.bad;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_message_done = message_done_ff;
   assign rsp_bad_header   = bad_header_ff;

`ifndef ASSERT_OFF
   a_num_out_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (head_job.num_out >= IDX_W'(1) && head_job.num_out <= IDX_W'(MAX_RESULTS)))
      else $error("job result count out of range");

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < head_job.num_out)
      else $error("result index beyond job");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (message_done_ff || bad_header_ff) |-> run_last_ff)
      else $error("message end or bad header not on last result of run");
`endif

endmodule

[design/seven_bit_group_codec_core.sv]
// ----------------------------------------------------------------------------
// seven_bit_group_codec_core
// Seven-bit group codec: encodes bytes into header-led groups or decodes them.
// ----------------------------------------------------------------------------
// An item's results pass through a job queue entry and then the output register.
// Throughput: one item per cycle while the job queue has room; the single
//   output register gives one result per cycle while rsp_ready is high, and
//   encode puts a header result ahead of the data results of each group.
// Reset: synchronous; clears direction to encode, group state, queue and rsp_valid.
module seven_bit_group_codec_core
   import sbgc_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_message_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_message_done,
   output logic              rsp_bad_header
);

   logic    direction_ff, direction_in;
   logic    reg_hit;
   cfg_type cfg;
   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type head_job;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[ADDR_W-1:2] == REG_DIRECTION);

   assign cfg.wr_en     = psel && penable && pwrite && reg_hit;
   assign cfg.direction = direction_ff;

   assign direction_in = cfg.wr_en ? pwdata[0] : direction_ff;
   assign prdata       = reg_hit ? {31'b0, direction_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   sbgc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_message_end (req_message_end),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   sbgc_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   sbgc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (queue_empty),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_done (rsp_message_done),
      .rsp_bad_header   (rsp_bad_header)
   );

endmodule
